[rtl/rc4_pkg.sv]
// RC4 stream cipher package: controller state encoding, register indexes
// and key reset constants. Used by rc4_stream_cipher_unit.
package rc4_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_WORDS  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd4;

    // "wStringb", byte 0 in the low bits
    localparam logic [63:0] KEY_WORD0_RESET = 64'h62676E6972745377;
    localparam logic [5:0]  KEY_LEN_RESET   = 6'd8;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_INIT   = 10'b00_0000_0010,
        ST_K_RD   = 10'b00_0000_0100,
        ST_K_ACC  = 10'b00_0000_1000,
        ST_K_WR   = 10'b00_0001_0000,
        ST_K_SWAP = 10'b00_0010_0000,
        ST_P_RD   = 10'b00_0100_0000,
        ST_P_J    = 10'b00_1000_0000,
        ST_P_SUM  = 10'b01_0000_0000,
        ST_P_OUT  = 10'b10_0000_0000
    } rc4_state_t;

endpackage

[rtl/rc4_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old value on a same-cycle write.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/rc4_stream_cipher_unit.sv]
// RC4 stream cipher top level: key registers, sequencer and permutation RAM.
// Depends on rc4_pkg and rc4_ram.
// Plain byte: S[i], S[j] and S[S[i]+S[j]] are read in turn on the single
// read port of the permutation RAM (ST_IDLE, ST_P_J, ST_P_SUM); the
// result is registered in ST_P_OUT once the output is free, and in_stall
// holds off the next byte until then. Start byte: identity fill, then key
// schedule (ST_K_RD/K_ACC/K_WR/K_SWAP per round), then as a plain byte.
// Reset: indices cleared, then an identity fill with in_stall high.
module rc4_stream_cipher_unit
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 start_message,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte
);

    localparam int ADDR_W = $clog2(SBOX_DEPTH);
    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    rc4_state_t state_reg, state_next;

    logic [63:0]        key_reg [KEY_WORDS];
    logic [5:0]         key_len_reg;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [ADDR_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0]  acc_reg, acc_next;
    logic [KIDX_W-1:0]  kidx_reg, kidx_next;
    logic [BYTE_W-1:0]  si_reg, si_next;
    logic [BYTE_W-1:0]  sj_reg, sj_next;
    logic [ADDR_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic               run_ksa_reg, run_ksa_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic [255:0]       key_vec;
    logic [7:0]         key_byte;
    logic [5:0]         eff_len;
    logic               in_xfer;
    logic               out_free;
    logic [BYTE_W-1:0]  keystream;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    assign key_vec  = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign key_byte = key_vec[{5'(kidx_reg), 3'b000} +: 8];

    always_comb
    begin
        priority if (key_len_reg == 6'd0)
        begin
            eff_len = 6'd1;
        end
        else if (key_len_reg > 6'(MAX_KEY_BYTES))
        begin
            eff_len = 6'(MAX_KEY_BYTES);
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    // value of S[sum] after the swap: the j write is still pending
    always_comb
    begin
        priority if (sum_reg == j_reg)
        begin
            keystream = si_reg;
        end
        else if (sum_reg == i_reg)
        begin
            keystream = sj_reg;
        end
        else
        begin
            keystream = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]  <= KEY_WORD0_RESET;
            key_reg[1]  <= '0;
            key_reg[2]  <= '0;
            key_reg[3]  <= '0;
            key_len_reg <= KEY_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KEY_0_7:   key_reg[0]  <= cfg_data;
                REG_KEY_8_15:  key_reg[1]  <= cfg_data;
                REG_KEY_16_23: key_reg[2]  <= cfg_data;
                REG_KEY_24_31: key_reg[3]  <= cfg_data;
                REG_KEY_LEN:   key_len_reg <= cfg_data[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        kidx_next      = kidx_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        sum_next       = sum_reg;
        data_next      = data_reg;
        run_ksa_next   = run_ksa_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_reg;
        ram_wdata      = sj_reg;
        ram_re         = 1'b0;
        ram_raddr      = i_reg + ADDR_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    data_next = data_byte;
                    if (start_message)
                    begin
                        i_next       = '0;
                        j_next       = '0;
                        n_next       = '0;
                        acc_next     = '0;
                        kidx_next    = '0;
                        run_ksa_next = 1'b1;
                        state_next   = ST_INIT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        i_next     = i_reg + ADDR_W'(1);
                        state_next = ST_P_J;
                    end
                end
            end
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = n_reg;
                ram_wdata = BYTE_W'(n_reg);
                n_next    = n_reg + ADDR_W'(1);
                if (n_reg == ADDR_W'(SBOX_DEPTH - 1))
                begin
                    state_next = run_ksa_reg ? ST_K_RD : ST_IDLE;
                end
            end
            ST_K_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = n_reg;
                state_next = ST_K_ACC;
            end
            ST_K_ACC:
            begin
                acc_next   = acc_reg + ram_rdata + key_byte;
                si_next    = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = acc_next;
                state_next = ST_K_WR;
            end
            ST_K_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = n_reg;
                ram_wdata  = ram_rdata;
                state_next = ST_K_SWAP;
            end
            ST_K_SWAP:
            begin
                ram_we    = 1'b1;
                ram_waddr = acc_reg;
                ram_wdata = si_reg;
                n_next    = n_reg + ADDR_W'(1);
                if (6'(kidx_reg) == eff_len - 6'd1)
                begin
                    kidx_next = '0;
                end
                else
                begin
                    kidx_next = kidx_reg + KIDX_W'(1);
                end
                if (n_reg == ADDR_W'(SBOX_DEPTH - 1))
                begin
                    run_ksa_next = 1'b0;
                    state_next   = ST_P_RD;
                end
                else
                begin
                    state_next = ST_K_RD;
                end
            end
            ST_P_RD:
            begin
                ram_re     = 1'b1;
                i_next     = i_reg + ADDR_W'(1);
                state_next = ST_P_J;
            end
            ST_P_J:
            begin
                si_next    = ram_rdata;
                j_next     = j_reg + ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = j_next;
                state_next = ST_P_SUM;
            end
            ST_P_SUM:
            begin
                sj_next    = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                sum_next   = si_reg + ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = sum_next;
                state_next = ST_P_OUT;
            end
            ST_P_OUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ keystream;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            acc_reg       <= '0;
            kidx_reg      <= '0;
            run_ksa_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            kidx_reg      <= kidx_next;
            run_ksa_reg   <= run_ksa_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        sum_reg      <= sum_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
